FILE: hw/rtl/quoted_argument_splitter_macros.svh
// Assertion macros shared by the quoted argument splitter RTL.
`ifndef QUOTED_ARGUMENT_SPLITTER_MACROS_SVH
`define QUOTED_ARGUMENT_SPLITTER_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge, skipping cycles in reset.
`define QAS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qas assertion failed");

// Check a property on every rising edge, reset included.
`define QAS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("qas assertion failed");

`else

`define QAS_ASSERT(name, clk, rst, prop)

`define QAS_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: hw/rtl/qas_pkg.sv
// Types and constants of the quoted argument splitter.
package qas_pkg;

  localparam int MaxResults = 4;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [7:0] MAX_ARGS_RESET = 8'd64;

  typedef enum logic [2:0] {
    KIND_BYTE = 3'd0,
    KIND_END  = 3'd1,
    KIND_OK   = 3'd2,
    KIND_UNDQ = 3'd3,
    KIND_UNSQ = 3'd4,
    KIND_MANY = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] cnt;
  } result_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [2:0]                n;
    result_t [MaxResults-1:0] res;
  } bundle_t;

  // Per-line parse state.
  typedef struct packed {
    logic       in_single;
    logic       in_double;
    logic       escape_next;
    logic       in_argument;
    logic [7:0] held_byte;
    logic       held_valid;
    logic [7:0] count;
    logic       overflowed;
  } state_t;

endpackage

FILE: hw/rtl/qas_step.sv
// Per-byte parse step: next state and the results one byte causes.
module qas_step
  import qas_pkg::*;
(
  input  state_t     state,
  input  logic [7:0] max_args,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  output state_t     state_next,
  output bundle_t    bundle
);

  always_comb begin
    state_t     st;
    bundle_t    bd;
    logic       ws;
    logic       do_write;
    logic       same;
    logic       other;
    kind_t      status;

    st       = state;
    bd       = '0;
    ws       = (ch == CH_SP) || ((ch >= CH_TAB) && (ch <= CH_CR));
    do_write = 1'b0;
    same     = 1'b0;
    other    = 1'b0;
    status   = KIND_OK;

    if (st.overflowed || (st.count > max_args)) begin
      // discard the rest of the line
      st.overflowed = 1'b1;
    end else if (ws && !st.escape_next && !st.in_single && !st.in_double) begin
      if (st.in_argument) begin
        if (st.held_valid) begin
          bd.res[bd.n[1:0]] = '{kind: KIND_BYTE, data: st.held_byte, cnt: st.count};
          bd.n = bd.n + 3'd1;
          st.held_valid = 1'b0;
        end
        bd.res[bd.n[1:0]] = '{kind: KIND_END, data: 8'd0, cnt: st.count};
        bd.n = bd.n + 3'd1;
        st.in_argument = 1'b0;
      end
    end else begin
      do_write = 1'b1;
      if (!st.escape_next) begin
        if (ch == CH_BSL) begin
          if (!st.in_single && !st.in_double) begin
            st.escape_next = 1'b1;
            do_write       = 1'b0;
          end
        end else if ((ch == CH_DQ) || (ch == CH_SQ)) begin
          same  = (ch == CH_DQ) ? st.in_double : st.in_single;
          other = (ch == CH_DQ) ? st.in_single : st.in_double;
          if (!other) begin
            if (same && st.held_valid) begin
              // retract the held backslash, keep the quote
              st.held_valid = 1'b0;
            end else begin
              do_write = 1'b0;
              if (ch == CH_DQ) begin
                st.in_double = !st.in_double;
              end else begin
                st.in_single = !st.in_single;
              end
              if (!st.in_argument) begin
                st.in_argument = 1'b1;
                if (st.count == 8'hFF) begin
                  st.overflowed = 1'b1;
                end else begin
                  st.count = st.count + 8'd1;
                end
              end
            end
          end
        end
      end
      if (do_write) begin
        st.escape_next = 1'b0;
        if (!st.in_argument) begin
          st.in_argument = 1'b1;
          if (st.count == 8'hFF) begin
            st.overflowed = 1'b1;
          end else begin
            st.count = st.count + 8'd1;
          end
        end
        if (st.held_valid) begin
          bd.res[bd.n[1:0]] = '{kind: KIND_BYTE, data: st.held_byte, cnt: st.count};
          bd.n = bd.n + 3'd1;
          st.held_valid = 1'b0;
        end
        if (ch == CH_BSL) begin
          st.held_byte  = ch;
          st.held_valid = 1'b1;
        end else begin
          bd.res[bd.n[1:0]] = '{kind: KIND_BYTE, data: ch, cnt: st.count};
          bd.n = bd.n + 3'd1;
        end
      end
    end

    if (end_of_line) begin
      if (st.held_valid) begin
        bd.res[bd.n[1:0]] = '{kind: KIND_BYTE, data: st.held_byte, cnt: st.count};
        bd.n = bd.n + 3'd1;
      end
      if (st.in_argument) begin
        bd.res[bd.n[1:0]] = '{kind: KIND_END, data: 8'd0, cnt: st.count};
        bd.n = bd.n + 3'd1;
      end
      if (st.overflowed || (st.count > max_args)) begin
        status = KIND_MANY;
      end else if (st.in_double) begin
        status = KIND_UNDQ;
      end else if (st.in_single) begin
        status = KIND_UNSQ;
      end else begin
        status = KIND_OK;
      end
      bd.res[bd.n[1:0]] = '{kind: status, data: 8'd0, cnt: st.count};
      bd.n = bd.n + 3'd1;
      st = '0;
    end

    state_next = st;
    bundle     = bd;
  end

endmodule

FILE: hw/rtl/qas_out_queue.sv
// Two-deep queue of result bundles, drained one result per transfer.
`include "quoted_argument_splitter_macros.svh"

module qas_out_queue
  import qas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bundle_t    push_bundle,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data,
  output logic [7:0] arg_count,
  output logic       last
);

  bundle_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [1:0] idx;
  bundle_t    head;
  result_t    cur;
  logic       head_last;
  logic       pop;

  assign head      = mem[rd_ptr];
  assign cur       = head.res[idx];
  assign head_last = ({1'b0, idx} == (head.n - 3'd1));
  assign out_valid = (fill != 2'd0);
  assign pop       = out_valid && out_ready && head_last;
  assign room      = (fill != 2'd2);

  assign kind      = cur.kind;
  assign data      = cur.data;
  assign arg_count = cur.cnt;
  assign last      = head_last;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
      idx    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        idx    <= 2'd0;
      end else if (out_valid && out_ready) begin
        idx <= idx + 2'd1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  `QAS_ASSERT(a_fill_bound, clk, rst, fill != 2'd3)
  `QAS_ASSERT(a_idx_in_bundle, clk, rst, out_valid |-> ({1'b0, idx} < head.n))
  `QAS_ASSERT(a_push_shows, clk, rst, (push && (fill == 2'd0)) |=> out_valid)
  `QAS_ASSERT(a_no_push_full, clk, rst, (fill == 2'd2) |-> !push)

endmodule

FILE: hw/rtl/quoted_argument_splitter.sv
// Top level of the quoted argument splitter: state, config register, result queue.
//
//   channel | signals                         | direction | payload
//   --------+---------------------------------+-----------+------------------------------
//   in      | in_valid / in_ready             | into      | ch, end_of_line
//   out     | out_valid / out_ready           | out of    | kind, data, arg_count, last
//   cfg     | cfg_valid / cfg_ready           | into      | cfg_data (max_args)
//
// One input byte is taken per cycle while in_ready is high; its parse step is a
// single combinational pass from the state registers into a two-deep queue of
// result bundles. Each byte gives zero to four results, and the output side
// drains one result per transfer, so with out_ready high the sustained rate is
// one byte per cycle when each byte makes at most one result, lower otherwise.
// Synchronous reset clears the parse state and the queue and loads max_args
// with 64. in_ready depends only on queue fill, not on out_ready; a stall at
// the output holds the current result and fills the queue, then drops in_ready.
`include "quoted_argument_splitter_macros.svh"

module quoted_argument_splitter
  import qas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data,
  output logic [7:0] arg_count,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  state_t     state;
  state_t     state_next;
  bundle_t    bundle;
  logic [7:0] max_args;
  logic       room;
  logic       in_xfer;

  // Accept whenever the queue has a free bundle slot.
  assign in_ready  = room;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  qas_step u_step (
    .state       (state),
    .max_args    (max_args),
    .ch          (ch),
    .end_of_line (end_of_line),
    .state_next  (state_next),
    .bundle      (bundle)
  );

  // Push only bytes that produce results; silent bytes just advance state.
  qas_out_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (in_xfer && (bundle.n != 3'd0)),
    .push_bundle (bundle),
    .room        (room),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data        (data),
    .arg_count   (arg_count),
    .last        (last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      max_args <= MAX_ARGS_RESET;
    end else begin
      if (in_xfer) begin
        state <= state_next;
      end
      if (cfg_valid && cfg_ready) begin
        max_args <= cfg_data;
      end
    end
  end

  `QAS_ASSERT(a_eol_clears, clk, rst, (in_xfer && end_of_line) |=> (state == '0))
  `QAS_ASSERT(a_eol_reports, clk, rst, (in_xfer && end_of_line) |-> (bundle.n != 3'd0))
  `QAS_ASSERT(a_idle_holds, clk, rst, !in_xfer |=> $stable(state))

endmodule

FILE: bench/tb_quoted_argument_splitter.sv
// Self-checking testbench for the quoted argument splitter: shell-style word splitting.
`timescale 1ns / 1ps

module tb_quoted_argument_splitter;
  import qas_pkg::*;

  // Whitespace bytes the package leaves unnamed.
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  // Watchdog limit for the whole run, with a wide margin over the worst case.
  localparam int CycleLimit  = 500000;
  // Result queue is two bundles deep; idle time that wait_idle adds after each phase.
  localparam int DrainCycles = 8;
  // Keep a broken run from flooding the log; every mismatch still counts.
  localparam int PrintCap    = 50;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic [4:0] gap;    // idle cycles before this byte is offered
    logic       drain;  // hold the byte until every predicted token has arrived
  } cmd_byte_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] cnt;
    logic       last;
  } split_token_t;

  logic       clk;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] ch          = 8'h00;
  logic       end_of_line = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [2:0] kind;
  logic [7:0] data;
  logic [7:0] arg_count;
  logic       last;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data    = 8'h00;

  cmd_byte_t    cmdline_bytes[$];
  split_token_t predicted_tokens[$];
  split_token_t step_tokens[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tokens_seen    = 0;

  quoted_argument_splitter dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .end_of_line(end_of_line),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data       (data),
    .arg_count  (arg_count),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Splitter predictor: a private copy of the per-line parse state and of
  // max_args, advanced once per accepted byte.
  // ---------------------------------------------------------------------------
  logic       sq_open        = 1'b0;
  logic       dq_open        = 1'b0;
  logic       escape_pending = 1'b0;
  logic       arg_open       = 1'b0;
  logic       held_bs_valid  = 1'b0;
  logic [7:0] held_bs        = 8'h00;
  logic [7:0] arg_cnt        = 8'h00;
  logic       discarding     = 1'b0;
  logic [7:0] max_args_shadow = MAX_ARGS_RESET;

  function automatic void emit(input kind_t k, input logic [7:0] d);
    step_tokens.push_back('{kind: k, data: d, cnt: arg_cnt, last: 1'b0});
  endfunction

  // Release a backslash that was held back in case a closing quote retracts it.
  function automatic void flush_held_bs();
    if (held_bs_valid) begin
      emit(KIND_BYTE, held_bs);
      held_bs_valid = 1'b0;
    end
  endfunction

  // Count saturates at 255; one more argument trips the overflow flag instead.
  function automatic void open_arg();
    if (!arg_open) begin
      arg_open = 1'b1;
      if (arg_cnt == 8'hFF) discarding = 1'b1;
      else arg_cnt = arg_cnt + 8'd1;
    end
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    escape_pending = 1'b0;
    open_arg();
    flush_held_bs();
    if (b == CH_BSL) begin
      held_bs       = b;
      held_bs_valid = 1'b1;
    end else begin
      emit(KIND_BYTE, b);
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic is_ws;
    logic same_open;
    logic other_open;
    is_ws = (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
    if (is_ws && !escape_pending && !sq_open && !dq_open) begin
      if (arg_open) begin
        flush_held_bs();
        emit(KIND_END, 8'h00);
        arg_open = 1'b0;
      end
      return;
    end
    if (!escape_pending) begin
      if (b == CH_BSL) begin
        // Outside quotes a backslash only escapes the next byte.
        if (!sq_open && !dq_open) begin
          escape_pending = 1'b1;
          return;
        end
      end else if (b == CH_DQ || b == CH_SQ) begin
        same_open  = (b == CH_DQ) ? dq_open : sq_open;
        other_open = (b == CH_DQ) ? sq_open : dq_open;
        if (!other_open) begin
          // Closing quote right after a held backslash: drop the backslash,
          // keep the quote as a literal and stay inside the quotes.
          if (same_open && held_bs_valid) begin
            held_bs_valid = 1'b0;
            put_byte(b);
            return;
          end
          if (b == CH_DQ) dq_open = !dq_open;
          else sq_open = !sq_open;
          open_arg();
          return;
        end
      end
    end
    put_byte(b);
  endfunction

  // Predict every token one byte causes and queue them in order.
  function automatic void split_step(input logic [7:0] b, input logic eol);
    kind_t status;
    step_tokens.delete();
    if (discarding || arg_cnt > max_args_shadow) discarding = 1'b1;
    else parse_byte(b);
    if (eol) begin
      flush_held_bs();
      if (arg_open) emit(KIND_END, 8'h00);
      if (discarding || arg_cnt > max_args_shadow) status = KIND_MANY;
      else if (dq_open) status = KIND_UNDQ;
      else if (sq_open) status = KIND_UNSQ;
      else status = KIND_OK;
      emit(status, 8'h00);
      sq_open        = 1'b0;
      dq_open        = 1'b0;
      escape_pending = 1'b0;
      arg_open       = 1'b0;
      held_bs_valid  = 1'b0;
      held_bs        = 8'h00;
      arg_cnt        = 8'h00;
      discarding     = 1'b0;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) predicted_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: offer the next queued byte after its idle gap, hold it until
  // the transfer, and predict its tokens at the accepting edge.
  // ---------------------------------------------------------------------------
  int        idle_cnt = 0;
  cmd_byte_t next_byte;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_cnt <= 0;
    end else begin
      if (in_valid && in_ready) split_step(ch, end_of_line);
      if (!in_valid || in_ready) begin
        if (cmdline_bytes.size() == 0 ||
            (cmdline_bytes[0].drain && predicted_tokens.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (idle_cnt < int'(cmdline_bytes[0].gap)) begin
          idle_cnt <= idle_cnt + 1;
          in_valid <= 1'b0;
        end else begin
          next_byte   = cmdline_bytes.pop_front();
          ch          <= next_byte.ch;
          end_of_line <= next_byte.eol;
          in_valid    <= 1'b1;
          idle_cnt    <= 0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: stall a random number of cycles after each transfer, with
  // calm stretches where ready stays high, and check every token received.
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  int   out_hold;
  logic out_calm   = 1'b0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < PrintCap) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_token();
    split_token_t want;
    if (predicted_tokens.size() == 0) begin
      report_mismatch($sformatf("token %0d unexpected: kind %0d data %02h count %0d",
                                tokens_seen, kind, data, arg_count));
      return;
    end
    want = predicted_tokens.pop_front();
    if (kind != want.kind)
      report_mismatch($sformatf("token %0d kind %0d, want %0d", tokens_seen, kind, want.kind));
    if (data != want.data)
      report_mismatch($sformatf("token %0d data %02h, want %02h", tokens_seen, data, want.data));
    if (arg_count != want.cnt)
      report_mismatch($sformatf("token %0d arg_count %0d, want %0d",
                                tokens_seen, arg_count, want.cnt));
    if (last != want.last)
      report_mismatch($sformatf("token %0d last %0b, want %0b", tokens_seen, last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      check_token();
      tokens_seen++;
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      out_hold = out_calm ? 0 : int'($urandom_range(0, 17));
      stall_left <= out_hold;
      out_ready  <= (out_hold == 0);
    end else if (!out_ready) begin
      if (stall_left <= 1) out_ready <= 1'b1;
      if (stall_left > 0) stall_left <= stall_left - 1;
    end
  end

  // Cycle counter and watchdog.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void queue_byte(input logic [7:0] c, input logic eol,
                                     input logic calm, input logic drain);
    cmd_byte_t nb;
    nb.ch    = c;
    nb.eol   = eol;
    nb.gap   = calm ? 5'd0 : 5'($urandom_range(0, 17));
    nb.drain = drain;
    cmdline_bytes.push_back(nb);
  endfunction

  // Queue a whole directed line; the final byte carries end_of_line when eol_at_end is set.
  function automatic void queue_text(input string s, input logic eol_at_end);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i], eol_at_end && (i == s.len() - 1), 1'b0, 1'b0);
  endfunction

  // Bias toward the bytes that steer the parser.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0, 1:    return CH_DQ;
      2, 3:    return CH_SQ;
      4, 5:    return CH_BSL;
      6:       return CH_SP;
      7:       return 8'($urandom_range(CH_TAB, CH_CR));
      8, 9:    return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  // One line built from words, quoted strings and escapes, mostly well formed;
  // some quotes are left open and some stretches are raw noise.
  task automatic add_random_line(input logic calm, input logic drain, inout int made);
    logic [7:0] text[$];
    logic [7:0] q;
    int         n_tok;
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          for (int k = $urandom_range(1, 4); k > 0; k--)
            text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(8'h61, 8'h7A)));
        end
        2, 3: begin
          q = ($urandom_range(0, 1) == 0) ? CH_DQ : CH_SQ;
          text.push_back(q);
          for (int k = $urandom_range(0, 4); k > 0; k--) text.push_back(pick_char());
          if ($urandom_range(0, 2) == 0) text.push_back(CH_BSL);
          if ($urandom_range(0, 5) != 0) text.push_back(q);
        end
        4: begin
          text.push_back(CH_BSL);
          text.push_back(($urandom_range(0, 1) == 0) ? pick_char()
                                                     : 8'($urandom_range(0, 255)));
        end
        default: begin
          for (int k = $urandom_range(1, 3); k > 0; k--) text.push_back(pick_char());
        end
      endcase
      // Separate most tokens; glue the rest together.
      if ($urandom_range(0, 3) != 0) begin
        for (int k = $urandom_range(1, 2); k > 0; k--)
          text.push_back(($urandom_range(0, 1) == 0) ? CH_SP
                                                     : 8'($urandom_range(CH_TAB, CH_CR)));
      end
    end
    foreach (text[i]) queue_byte(text[i], i == text.size() - 1, calm, drain && i == 0);
    made += text.size();
  endtask

  task automatic add_random_lines(input int budget);
    int   made;
    logic drain;
    made  = 0;
    drain = 1'b1;  // first line of a phase waits for the block to drain
    while (made < budget) begin
      add_random_line($urandom_range(0, 3) == 0, drain, made);
      drain = ($urandom_range(0, 14) == 0);
    end
  endtask

  // Hold until every byte is sent and every token checked, then idle for
  // DrainCycles clock edges. Sample between edges so the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (cmdline_bytes.size() != 0 || in_valid || predicted_tokens.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_max_args(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    max_args_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed lines, run with the reset value of max_args.
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);     // zero byte and all-ones byte as data
    queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    queue_text("a\t\\ ", 1'b0);               // tab ends a word, escaped space is literal
    queue_byte(CH_LF, 1'b0, 1'b0, 1'b0);
    queue_byte(CH_VT, 1'b0, 1'b0, 1'b0);
    queue_byte(CH_FF, 1'b0, 1'b0, 1'b0);
    queue_byte(CH_CR, 1'b1, 1'b0, 1'b0);
    queue_text("\"'\\\"\"", 1'b1);            // backslash retracted by the closing quote
    queue_text("'\"\\", 1'b1);                // open single quote, held backslash at the end
    queue_text("\\", 1'b1);                   // trailing escape outside quotes
    queue_text("''", 1'b1);                   // empty quoted argument
    queue_text("\\\\\"\"", 1'b1);             // escaped backslash retracted inside quotes
    wait_idle();

    write_max_args(8'd0);                     // everything after the byte that opens the first argument drops
    add_random_lines(50);
    wait_idle();

    write_max_args(8'd255);
    add_random_lines(70);
    wait_idle();

    write_max_args(8'd1);
    add_random_lines(60);
    wait_idle();

    write_max_args(8'd3);
    add_random_lines(80);
    wait_idle();

    write_max_args(8'($urandom_range(2, 40)));
    add_random_lines(80);
    wait_idle();

    write_max_args(MAX_ARGS_RESET);
    add_random_lines(60);
    wait_idle();

    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
